>>> hw/rtl/mdc_pkg.sv
// Shared types, constants and helpers for the MESI directory controller.
// No dependencies; imported by every module of the block.
package mdc_pkg;

  localparam int DIR_ENTRIES = 256;
  localparam int IDX_W       = $clog2(DIR_ENTRIES);
  localparam int PROC_W      = 3;
  localparam int CMD_W       = 3;
  localparam int MASK_W      = 8;
  localparam int CNT_W       = 4;
  localparam int LAT_W       = 12;
  localparam int HOP_W       = 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [HOP_W-1:0] HOP_RESET = 8'd1;

  // register index, taken from paddr[2]
  localparam logic REG_HOP_LATENCY = 1'b0;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_INVAL     = 3'd2,
    CMD_WRITEBACK = 3'd3,
    CMD_EVICT     = 3'd4,
    CMD_QUERY     = 3'd5
  } cmd_e;

  typedef struct packed {
    logic              present;
    logic              dirty;
    logic [MASK_W-1:0] sharers;
    logic              owner_valid;
    logic [PROC_W-1:0] owner;
    mesi_e             st;
  } entry_t;

  typedef struct packed {
    logic              granted;
    logic [1:0]        new_state;
    logic [MASK_W-1:0] inv_mask;
    logic [CNT_W-1:0]  inv_count;
    logic [LAT_W-1:0]  latency;
    logic [1:0]        req_state;
    logic              read_allowed;
    logic              write_allowed;
    logic              dirty;
  } result_t;

  function automatic logic [MASK_W-1:0] proc_bit(input logic [PROC_W-1:0] p);
    return MASK_W'(1) << p;
  endfunction

  function automatic logic [CNT_W-1:0] pop_count(input logic [MASK_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/mdc_dir_mem.sv
// Directory storage: entry array with registered read and per-entry valid bits.
// Depends on mdc_pkg. An entry never written reads as all zeros.
module mdc_dir_mem
  import mdc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output entry_t           rd_entry_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  entry_t           wr_entry_i
);

  entry_t                 mem_q [DIR_ENTRIES];
  logic [DIR_ENTRIES-1:0] vld_q;
  entry_t                 rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_idx_i];
      end
    end
  end

  assign rd_entry_o = rd_vld_q ? rd_q : '0;

endmodule

>>> hw/rtl/mdc_update.sv
// Coherence update: next directory entry and result for one command.
// Depends on mdc_pkg. Purely combinational.
module mdc_update
  import mdc_pkg::*;
(
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [PROC_W-1:0] req_i,
  input  logic [HOP_W-1:0]  hop_i,
  input  entry_t            cur_i,
  output entry_t            nxt_o,
  output result_t           res_o
);

  logic              owned;
  logic              owned_n;
  logic [MASK_W-1:0] rbit;
  logic [MASK_W-1:0] obit;
  logic [MASK_W-1:0] holders;
  logic [MASK_W-1:0] inv;
  logic [CNT_W-1:0]  hops;
  logic              granted;
  entry_t            nxt;
  mesi_e             rstate;

  assign rbit    = proc_bit(req_i);
  assign obit    = proc_bit(cur_i.owner);
  assign owned   = cur_i.owner_valid && (cur_i.owner == req_i);
  assign holders = (cur_i.sharers | (cur_i.owner_valid ? obit : '0)) & ~rbit;

  always_comb begin
    nxt     = cur_i;
    inv     = '0;
    hops    = '0;
    granted = 1'b0;
    case (cmd_e'(cmd_i))
      CMD_READ: begin
        granted     = 1'b1;
        nxt.present = 1'b1;
        if (cur_i.st == ST_I) begin
          nxt.st          = ST_E;
          nxt.owner       = req_i;
          nxt.owner_valid = 1'b1;
        end else if (cur_i.st == ST_S) begin
          nxt.sharers = cur_i.sharers | rbit;
        end else if (!owned) begin
          if (cur_i.owner_valid) begin
            hops = CNT_W'(1);
          end
          nxt.sharers     = cur_i.sharers | rbit | (cur_i.owner_valid ? obit : '0);
          nxt.owner_valid = 1'b0;
          nxt.owner       = '0;
          nxt.st          = ST_S;
        end
      end
      CMD_WRITE: begin
        granted     = 1'b1;
        nxt.present = 1'b1;
        if (cur_i.st == ST_S) begin
          inv         = holders;
          hops        = pop_count(holders);
          nxt.sharers = '0;
        end else if (cur_i.st inside {ST_E, ST_M} && !owned && cur_i.owner_valid) begin
          inv  = obit;
          hops = CNT_W'(1);
        end
        nxt.st          = ST_M;
        nxt.owner       = req_i;
        nxt.owner_valid = 1'b1;
        nxt.dirty       = 1'b1;
      end
      CMD_INVAL: begin
        granted         = 1'b1;
        nxt.present     = 1'b1;
        inv             = holders;
        nxt.st          = ST_I;
        nxt.owner_valid = 1'b0;
        nxt.owner       = '0;
        nxt.sharers     = '0;
      end
      CMD_WRITEBACK: begin
        nxt.present = 1'b1;
        if (owned) begin
          nxt.dirty = 1'b0;
          granted   = 1'b1;
        end
      end
      CMD_EVICT: begin
        granted     = 1'b1;
        nxt.present = 1'b1;
        nxt.sharers = cur_i.sharers & ~rbit;
        if (owned) begin
          nxt.owner_valid = 1'b0;
          nxt.owner       = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign owned_n = nxt.owner_valid && (nxt.owner == req_i);

  always_comb begin
    rstate = ST_I;
    if (nxt.st == ST_S && (nxt.sharers & rbit) != '0) begin
      rstate = ST_S;
    end else if (nxt.st inside {ST_E, ST_M} && owned_n) begin
      rstate = nxt.st;
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.granted   = granted;
    res_o.inv_mask  = inv;
    res_o.inv_count = pop_count(inv);
    res_o.latency   = LAT_W'(hop_i) + LAT_W'(hop_i) * LAT_W'(hops);
    if (!nxt.present) begin
      res_o.req_state     = ST_I;
      res_o.read_allowed  = 1'b1;
      res_o.write_allowed = 1'b1;
    end else begin
      res_o.new_state     = nxt.st;
      res_o.req_state     = rstate;
      res_o.read_allowed  = (rstate != ST_I);
      res_o.write_allowed = (nxt.st == ST_M) && owned_n;
      res_o.dirty         = nxt.dirty;
    end
  end

  assign nxt_o = nxt;

endmodule

>>> hw/rtl/mesi_directory_controller_core.sv
// Top level of the MESI directory controller: pipeline, bypass, APB register.
// Depends on mdc_pkg, mdc_dir_mem and mdc_update.
//
// The directory holds one entry per line index and answers every command with
// one result. One transfer is accepted per clock while the output drains. The
// edge that accepts a command also captures the registered directory read. In
// the following cycle the state update runs, and at the edge where it advances
// it writes the entry back and loads the output register. A result that waits
// on out_ready_i holds the command behind it, and that command blocks the
// input. Back-to-back commands to the same line are served from a bypass of
// the last write, so no bubble is inserted. Reset marks all entries invalid
// at once through per-entry valid bits; there is no clearing pass.
// hop_latency sits at byte address 0 and resets to 1.
module mesi_directory_controller_core
  import mdc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [PROC_W-1:0]  requestor_i,
  input  logic [IDX_W-1:0]   line_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               granted_o,
  output logic [1:0]         new_state_o,
  output logic [MASK_W-1:0]  invalidate_mask_o,
  output logic [CNT_W-1:0]   invalidate_count_o,
  output logic [LAT_W-1:0]   latency_o,
  output logic [1:0]         requestor_state_o,
  output logic               read_allowed_o,
  output logic               write_allowed_o,
  output logic               dirty_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [HOP_W-1:0]  hop_q;
  logic              s1_v_q;
  logic [CMD_W-1:0]  s1_cmd_q;
  logic [PROC_W-1:0] s1_req_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic              fwd_v_q;
  logic [IDX_W-1:0]  fwd_idx_q;
  entry_t            fwd_entry_q;
  logic              out_v_q;
  result_t           res_q;

  logic    in_xfer;
  logic    s1_adv;
  entry_t  rd_entry;
  entry_t  cur;
  entry_t  nxt;
  result_t res;

  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  mdc_dir_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_xfer),
    .rd_idx_i   (line_index_i),
    .rd_entry_o (rd_entry),
    .wr_en_i    (s1_adv),
    .wr_idx_i   (s1_idx_q),
    .wr_entry_i (nxt)
  );

  // last write bypass for same-line back-to-back transfers
  assign cur = (fwd_v_q && fwd_idx_q == s1_idx_q) ? fwd_entry_q : rd_entry;

  mdc_update u_update (
    .cmd_i (s1_cmd_q),
    .req_i (s1_req_q),
    .hop_i (hop_q),
    .cur_i (cur),
    .nxt_o (nxt),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hop_q   <= HOP_RESET;
      s1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_HOP_LATENCY) begin
        hop_q <= pwdata[HOP_W-1:0];
      end
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (s1_adv) begin
        fwd_v_q <= 1'b1;
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q <= command_i;
      s1_req_q <= requestor_i;
      s1_idx_q <= line_index_i;
    end
    if (s1_adv) begin
      fwd_idx_q   <= s1_idx_q;
      fwd_entry_q <= nxt;
      res_q       <= res;
    end
  end

  assign prdata = (paddr[2] == REG_HOP_LATENCY) ? {{(PDATA_W-HOP_W){1'b0}}, hop_q} : '0;
  assign pready = 1'b1;

  assign out_valid_o        = out_v_q;
  assign granted_o          = res_q.granted;
  assign new_state_o        = res_q.new_state;
  assign invalidate_mask_o  = res_q.inv_mask;
  assign invalidate_count_o = res_q.inv_count;
  assign latency_o          = res_q.latency;
  assign requestor_state_o  = res_q.req_state;
  assign read_allowed_o     = res_q.read_allowed;
  assign write_allowed_o    = res_q.write_allowed;
  assign dirty_out_o        = res_q.dirty;

endmodule

>>> hw/rtl/mdc_checker.sv
// Port-level checks for mesi_directory_controller_core, attached by bind.
// Depends on mdc_pkg.
module mdc_checker
  import mdc_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               granted_o,
  input logic [MASK_W-1:0]  invalidate_mask_o,
  input logic [CNT_W-1:0]   invalidate_count_o,
  input logic [LAT_W-1:0]   latency_o,
  input logic [1:0]         requestor_state_o,
  input logic               read_allowed_o,
  input logic               write_allowed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(invalidate_mask_o)
      && $stable(latency_o) && $stable(granted_o))
    else $error("result changed while stalled");

  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no result two cycles after input transfer");

  a_inv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> invalidate_count_o == CNT_W'($countones(invalidate_mask_o)))
    else $error("invalidate count does not match mask");

  a_write_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_allowed_o && requestor_state_o != ST_I
      |-> read_allowed_o && requestor_state_o == ST_M)
    else $error("write permission without modified ownership");

endmodule

bind mesi_directory_controller_core mdc_checker u_mdc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .granted_o          (granted_o),
  .invalidate_mask_o  (invalidate_mask_o),
  .invalidate_count_o (invalidate_count_o),
  .latency_o          (latency_o),
  .requestor_state_o  (requestor_state_o),
  .read_allowed_o     (read_allowed_o),
  .write_allowed_o    (write_allowed_o)
);
